FILE: rtl/rnsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnsc_pkg
// Shared types and constants for the relative-norm steady-state checker.
// ----------------------------------------------------------------------------
package rnsc_pkg;

  localparam int unsigned ValueBits = 32;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned AccBits   = 64;
  localparam int unsigned RatioBits = 32;
  localparam int unsigned CfgIdxBits = 2;
  localparam int unsigned CfgDataBits = 32;

  // configuration register indexes
  localparam logic [CfgIdxBits-1:0] RegNormKind  = 2'd0;
  localparam logic [CfgIdxBits-1:0] RegSteadyTol = 2'd1;
  localparam logic [CfgIdxBits-1:0] RegZeroEps   = 2'd2;

  // norm kinds
  localparam logic [1:0] NormMax = 2'd0;
  localparam logic [1:0] NormSum = 2'd1;
  localparam logic [1:0] NormL2  = 2'd2;

  localparam logic [AccBits-1:0] QOne = AccBits'(64'h1_0000);

  typedef struct packed {
    logic signed [ValueBits-1:0] new_value;
    logic signed [ValueBits-1:0] old_value;
    logic                        is_pressure;
    logic                        is_free;
    logic                        last_item;
  } in_word_t;

  typedef struct packed {
    logic [RatioBits-1:0] velocity_ratio;
    logic [RatioBits-1:0] pressure_ratio;
    logic                 steady;
  } out_word_t;

  typedef enum logic [2:0] {
    StIdle,
    StSqrt,
    StDiv,
    StNext,
    StOut
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic accum;       // add the accepted word into the accumulators
    logic fin_start;   // latch accumulators, start finishing norms
    logic sqrt_step;   // one root bit pair
    logic div_load;    // load the divider for the selected field
    logic div_step;    // one quotient bit
    logic div_store;   // store the selected ratio
    logic sel_pres;    // 0 velocity field, 1 pressure field
    logic out_load;    // load the output register
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic sqrt_done;
    logic div_done;
  } stat_t;

endpackage

FILE: rtl/rnsc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnsc_datapath
// Accumulators, four iterative square-root lanes with a shared step counter
// for four norms and a shared restoring divider for both ratios.
// ----------------------------------------------------------------------------
module rnsc_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rnsc_pkg::ctrl_t     ctrl_i,
  input  rnsc_pkg::in_word_t  word_i,
  input  logic [1:0]          norm_kind_i,
  input  logic [31:0]         steady_tol_i,
  input  logic [31:0]         zero_eps_i,
  output rnsc_pkg::stat_t     stat_o,
  output rnsc_pkg::out_word_t out_o
);

  localparam int unsigned AB = rnsc_pkg::AccBits;
  localparam int unsigned VB = rnsc_pkg::ValueBits;

  logic [AB-1:0] acc_q [4];  // vel change, vel size, pre change, pre size
  logic [AB-1:0] acc_d [4];

  // magnitudes of the difference and of the new value
  logic signed [VB:0] diff;
  logic [VB:0]        dm;
  logic [VB:0]        sm;
  logic [AB-1:0]      mags [2];

  assign diff = {word_i.new_value[VB-1], word_i.new_value}
              - {word_i.old_value[VB-1], word_i.old_value};
  assign dm = diff[VB] ? (VB+1)'(-diff) : diff;
  assign sm = word_i.new_value[VB-1] ? (VB+1)'(-{1'b1, word_i.new_value})
                                     : {1'b0, word_i.new_value};
  assign mags[0] = AB'(dm);
  assign mags[1] = AB'(sm);

  function automatic logic [AB-1:0] acc_next(input logic [1:0] kind,
                                             input logic [AB-1:0] acc,
                                             input logic [AB-1:0] m);
    logic [AB:0]   s;
    logic [AB-1:0] sq;
    logic [AB-1:0] r;
    begin
      sq = (m[AB-1:32] != '0) ? '1 : m[31:0] * m[31:0];
      if (kind == rnsc_pkg::NormSum) begin
        s = {1'b0, acc} + {1'b0, m};
        r = s[AB] ? '1 : s[AB-1:0];
      end else if (kind == rnsc_pkg::NormL2) begin
        s = {1'b0, acc} + {1'b0, sq};
        r = s[AB] ? '1 : s[AB-1:0];
      end else begin
        r = (m > acc) ? m : acc;
      end
      acc_next = r;
    end
  endfunction

  // accumulator update, cleared when the vector is finished
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      acc_d[i] = acc_q[i];
      if (ctrl_i.fin_start) begin
        acc_d[i] = '0;
      end else if (ctrl_i.accum && word_i.is_free &&
                   (word_i.is_pressure == (i >= 2))) begin
        acc_d[i] = acc_next(norm_kind_i, acc_q[i], mags[i % 2]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) acc_q[i] <= '0;
    end else begin
      for (int i = 0; i < 4; i++) acc_q[i] <= acc_d[i];
    end
  end

  // square root: four lanes share one step counter, one bit pair a cycle
  logic [AB-1:0] rx_q   [4];
  logic [AB-1:0] rres_q [4];
  logic [AB-1:0] rbit_q;
  logic [AB-1:0] nrm [4];
  logic          l2_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.fin_start) begin
      for (int i = 0; i < 4; i++) begin
        rx_q[i]   <= acc_q[i];
        rres_q[i] <= '0;
      end
      rbit_q <= AB'(1) << (AB - 2);
      l2_q   <= (norm_kind_i == rnsc_pkg::NormL2);
    end else if (ctrl_i.sqrt_step) begin
      for (int i = 0; i < 4; i++) begin
        if (rx_q[i] >= rres_q[i] + rbit_q) begin
          rx_q[i]   <= rx_q[i] - (rres_q[i] + rbit_q);
          rres_q[i] <= (rres_q[i] >> 1) + rbit_q;
        end else begin
          rres_q[i] <= rres_q[i] >> 1;
        end
      end
      rbit_q <= rbit_q >> 2;
    end
  end

  assign stat_o.sqrt_done = !l2_q || (rbit_q == '0);
  always_comb begin
    for (int i = 0; i < 4; i++) nrm[i] = l2_q ? rres_q[i] : rx_q[i];
  end

  // long division: 64 integer bits + 16 fraction bits, one bit a cycle
  localparam int unsigned QB = AB + rnsc_pkg::FracBits;
  logic [QB-1:0] dnum_q;
  logic [AB:0]   drem_q;
  logic [AB-1:0] dden_q;
  logic [QB-1:0] dquo_q;
  logic [6:0]    dcnt_q;
  logic [AB-1:0] den_sel;
  logic [AB-1:0] num_sel;
  logic [AB:0]   rem_sh;
  logic [31:0]   ratio;
  logic [31:0]   vr_q;

  assign num_sel = ctrl_i.sel_pres ? nrm[2] : nrm[0];
  assign den_sel = ctrl_i.sel_pres ? nrm[3] : nrm[1];
  assign rem_sh  = {drem_q[AB-1:0], dnum_q[QB-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
    end else if (ctrl_i.div_load) begin
      dcnt_q <= 7'(QB);
    end else if (ctrl_i.div_step && dcnt_q != '0) begin
      dcnt_q <= dcnt_q - 7'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.div_load) begin
      dnum_q <= {num_sel, 16'h0};
      drem_q <= '0;
      dquo_q <= '0;
      dden_q <= (den_sel == '0 || den_sel < AB'(zero_eps_i)) ? rnsc_pkg::QOne
                                                             : den_sel;
    end else if (ctrl_i.div_step) begin
      dnum_q <= dnum_q << 1;
      if (rem_sh >= {1'b0, dden_q}) begin
        drem_q <= rem_sh - {1'b0, dden_q};
        dquo_q <= {dquo_q[QB-2:0], 1'b1};
      end else begin
        drem_q <= rem_sh;
        dquo_q <= {dquo_q[QB-2:0], 1'b0};
      end
    end
  end

  assign stat_o.div_done = (dcnt_q == '0);
  assign ratio = (dquo_q[QB-1:32] != '0) ? '1 : dquo_q[31:0];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.div_store && !ctrl_i.sel_pres) vr_q <= ratio;
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      out_o.velocity_ratio <= vr_q;
      out_o.pressure_ratio <= ratio;
      out_o.steady         <= (vr_q < steady_tol_i) && (ratio < steady_tol_i);
    end
  end

endmodule

FILE: rtl/rnsc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnsc_ctrl
// Sequencer: accumulate words, then root (euclidean norm only), divide twice and present result.
// ----------------------------------------------------------------------------
module rnsc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_last_i,
  input  logic            out_stall_i,
  input  rnsc_pkg::stat_t stat_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  output rnsc_pkg::ctrl_t ctrl_o
);

  rnsc_pkg::state_e state_q, state_d;
  logic pres_q, pres_d;
  logic out_valid_q, out_valid_d;
  logic acc_in;
  logic fin_q;  // first StSqrt cycle: accumulators move into the root unit

  assign acc_in = in_valid_i && !in_stall_o;

  // next state
  always_comb begin
    state_d = state_q;
    pres_d  = pres_q;
    unique case (state_q)
      rnsc_pkg::StIdle: if (acc_in && in_last_i) state_d = rnsc_pkg::StSqrt;
      rnsc_pkg::StSqrt: if (stat_i.sqrt_done && !fin_q) begin
        state_d = rnsc_pkg::StDiv;
        pres_d  = 1'b0;
      end
      rnsc_pkg::StDiv: if (stat_i.div_done) begin
        state_d = pres_q ? rnsc_pkg::StOut : rnsc_pkg::StNext;
      end
      rnsc_pkg::StNext: begin
        state_d = rnsc_pkg::StDiv;
        pres_d  = 1'b1;
      end
      rnsc_pkg::StOut: if (!out_valid_q || !out_stall_i) state_d = rnsc_pkg::StIdle;
      default: state_d = rnsc_pkg::StIdle;
    endcase
  end

  // outputs
  always_comb begin
    ctrl_o = '0;
    ctrl_o.sel_pres = pres_q;
    in_stall_o = (state_q != rnsc_pkg::StIdle);
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      rnsc_pkg::StIdle: begin
        ctrl_o.accum     = acc_in;
        ctrl_o.fin_start = 1'b0;
      end
      rnsc_pkg::StSqrt: begin
        ctrl_o.sel_pres = 1'b0;
        if (fin_q) begin
          ctrl_o.fin_start = 1'b1;
        end else begin
          ctrl_o.sqrt_step = !stat_i.sqrt_done;
          ctrl_o.div_load  = stat_i.sqrt_done;
        end
      end
      rnsc_pkg::StDiv: begin
        ctrl_o.div_step  = !stat_i.div_done;
        ctrl_o.div_store = stat_i.div_done;
      end
      rnsc_pkg::StNext: begin
        ctrl_o.div_load = 1'b1;
        ctrl_o.sel_pres = 1'b1;
      end
      rnsc_pkg::StOut: begin
        if (!out_valid_q || !out_stall_i) begin
          ctrl_o.out_load = 1'b1;
          out_valid_d     = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // state registers; the last word is folded in at its accepting edge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rnsc_pkg::StIdle;
      pres_q      <= 1'b0;
      out_valid_q <= 1'b0;
      fin_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      pres_q      <= pres_d;
      out_valid_q <= out_valid_d;
      fin_q       <= acc_in && in_last_i;
    end
  end

  assign out_valid_o = out_valid_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != rnsc_pkg::StIdle) |-> in_stall_o)
    else $error("word accepted while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("result overwritten while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_in && in_last_i) |=> (state_q == rnsc_pkg::StSqrt))
    else $error("last word did not start finishing");

endmodule

FILE: rtl/relative_norm_steady_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// relative_norm_steady_check
// Relative increment norm convergence check over one solution vector.
// ----------------------------------------------------------------------------
// One word is taken per cycle while a vector streams in. After the last word
// the block runs the bit-serial root unit (euclidean norm only) and then the
// shared one-bit-a-cycle divider, once for each ratio; no input word is taken
// in that time. The result sits in an output register until it is taken; a
// new result waits, and the input stays stalled, while the previous one is
// still held there.
module relative_norm_steady_check (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [31:0]                   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  rnsc_pkg::in_word_t            in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output rnsc_pkg::out_word_t           out_word_o
);

  logic [1:0]  norm_kind_q;
  logic [31:0] steady_tol_q;
  logic [31:0] zero_eps_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      norm_kind_q  <= rnsc_pkg::NormMax;
      steady_tol_q <= 32'd66;
      zero_eps_q   <= 32'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rnsc_pkg::RegNormKind:  norm_kind_q  <= cfg_data_i[1:0];
        rnsc_pkg::RegSteadyTol: steady_tol_q <= cfg_data_i;
        rnsc_pkg::RegZeroEps:   zero_eps_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rnsc_pkg::ctrl_t ctrl;
  rnsc_pkg::stat_t stat;

  rnsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (in_word_i.last_item),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .ctrl_o      (ctrl)
  );

  rnsc_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .word_i       (in_word_i),
    .norm_kind_i  (norm_kind_q),
    .steady_tol_i (steady_tol_q),
    .zero_eps_i   (zero_eps_q),
    .stat_o       (stat),
    .out_o        (out_word_o)
  );

endmodule
